// File: rtl/ks_pkg.sv
// Shared types and constants of the k smallest selection block.
package ks_pkg;

	// Width and reset value of the select count register
	localparam int unsigned SELECT_COUNT_W = 7;
	localparam logic [SELECT_COUNT_W-1:0] SELECT_COUNT_RESET = 7'd1;

	// Sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_COLLECT = 2'b01,
		ST_DRAIN   = 2'b10
	} state_t;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic ins_en;
		logic shift_en;
	} cell_ctrl_t;

endpackage

// File: rtl/ks_stream_if.sv
// Request channels: incoming samples and outgoing results.
interface ks_sample_if #(
	parameter int unsigned VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] sample;
	logic                   end_of_set;

	modport source (output valid, output sample, output end_of_set, input ready);
	modport sink   (input valid, input sample, input end_of_set, output ready);
endinterface

interface ks_result_if #(
	parameter int unsigned VALUE_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] smallest_value;
	logic                   last_result;

	modport source (output valid, output smallest_value, output last_result, input ready);
	modport sink   (input valid, input smallest_value, input last_result, output ready);
endinterface

// File: rtl/ks_cell.sv
// One cell of the sorted insertion chain.
module ks_cell #(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                   clk,
	input  ks_pkg::cell_ctrl_t     ctrl,
	input  logic [VALUE_WIDTH-1:0] new_value,
	input  logic                   occupied,
	input  logic [VALUE_WIDTH-1:0] left_value,
	input  logic                   left_gt,
	input  logic [VALUE_WIDTH-1:0] right_value,
	output logic [VALUE_WIDTH-1:0] value,
	output logic                   gt
);
	import ks_pkg::*;

	logic [VALUE_WIDTH-1:0] value_q;

	// An empty cell counts as holding a value above any sample
	assign gt    = !occupied || (value_q > new_value);
	assign value = value_q;

	// Insert: take the left neighbour's value if it moves too, else the new one.
	// Drain: take the right neighbour's value.
	always_ff @(posedge clk) begin
		if (ctrl.ins_en && gt) begin
			value_q <= left_gt ? left_value : new_value;
		end else if (ctrl.shift_en) begin
			value_q <= right_value;
		end
	end

endmodule

// File: rtl/k_smallest_select.sv
// Top level of the k smallest selection block.
//
// Samples stream in one request per cycle while the block collects; each is inserted as
// it is accepted into a chain of MAX_SELECT compare-and-shift cells that holds the
// smallest values seen so far in ascending order (equal values each keep an entry;
// when full, the largest is dropped). After the request flagged end_of_set, the block
// emits n = min(k, held) results, ascending, one per cycle as the sink takes them, with
// the last one marked; k is select_count saturated to MAX_SELECT, and k of zero emits
// nothing. Results leave from the first cell while the chain shifts towards it, and no
// sample is taken until the run is done. The set then starts empty. Write select_count
// only while the block is idle.
module k_smallest_select #(
	parameter int unsigned MAX_SELECT  = 64,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	ks_sample_if.sink                           samples,
	ks_result_if.source                         results,
	input  logic                                cfg_we,
	input  logic [ks_pkg::SELECT_COUNT_W-1:0]   cfg_wdata
);
	import ks_pkg::*;

	localparam int unsigned CW = $clog2(MAX_SELECT + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SELECT);

	state_t                    state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             remain_q;
	logic [SELECT_COUNT_W-1:0] select_count_q;

	logic                      in_accept;
	logic                      out_accept;
	logic [CW-1:0]             count_ins;
	logic [CW-1:0]             k_sat;
	logic [CW-1:0]             run_len;
	cell_ctrl_t                ctrl;

	logic [VALUE_WIDTH-1:0]    cell_value [MAX_SELECT];
	logic                      cell_gt    [MAX_SELECT];

	// Handshakes
	assign samples.ready = (state_q == ST_COLLECT);
	assign results.valid = (state_q == ST_DRAIN);
	assign in_accept     = samples.valid && samples.ready;
	assign out_accept    = results.valid && results.ready;

	assign ctrl.ins_en   = in_accept;
	assign ctrl.shift_en = out_accept;

	// Results leave from the head of the chain
	assign results.smallest_value = cell_value[0];
	assign results.last_result    = (remain_q == CW'(1));

	// Fill after an insert, saturated k and length of the run
	assign count_ins = (count_q < MAX_CNT) ? count_q + CW'(1) : count_q;
	assign k_sat     = (select_count_q > SELECT_COUNT_W'(MAX_SELECT)) ? MAX_CNT
	                                                                  : CW'(select_count_q);
	assign run_len   = (k_sat < count_ins) ? k_sat : count_ins;

	// Cell chain
	for (genvar i = 0; i < MAX_SELECT; i++) begin : g_cell
		logic [VALUE_WIDTH-1:0] left_v;
		logic                   left_g;
		logic [VALUE_WIDTH-1:0] right_v;

		if (i == 0) begin : g_head
			assign left_v = '0;
			assign left_g = 1'b0;
		end else begin : g_body
			assign left_v = cell_value[i-1];
			assign left_g = cell_gt[i-1];
		end

		if (i == MAX_SELECT - 1) begin : g_tail
			assign right_v = cell_value[i];
		end else begin : g_inner
			assign right_v = cell_value[i+1];
		end

		ks_cell #(
			.VALUE_WIDTH (VALUE_WIDTH)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.new_value   (samples.sample),
			.occupied    (CW'(i) < count_q),
			.left_value  (left_v),
			.left_gt     (left_g),
			.right_value (right_v),
			.value       (cell_value[i]),
			.gt          (cell_gt[i])
		);
	end

	// Select count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_count_q <= SELECT_COUNT_RESET;
		end else if (cfg_we) begin
			select_count_q <= cfg_wdata;
		end
	end

	// Sequencer: collect a set, then drain the run unless it is empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_COLLECT;
			count_q  <= '0;
			remain_q <= '0;
		end else begin
			unique case (state_q)
				ST_COLLECT: begin
					if (in_accept) begin
						if (!samples.end_of_set) begin
							count_q <= count_ins;
						end else if (run_len == '0) begin
							count_q <= '0;
						end else begin
							count_q  <= count_ins;
							remain_q <= run_len;
							state_q  <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (out_accept) begin
						remain_q <= remain_q - CW'(1);
						if (remain_q == CW'(1)) begin
							count_q <= '0;
							state_q <= ST_COLLECT;
						end
					end
				end
				default: begin
					state_q <= ST_COLLECT;
				end
			endcase
		end
	end

	// Checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		samples.ready |-> !results.valid)
		else $error("sample side open while a run is pending");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (remain_q != '0))
		else $error("drain with no result left");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CNT)
		else $error("fill count beyond chain length");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_accept && results.last_result) |=> (samples.ready && (count_q == '0)))
		else $error("set not restarted after last result");

endmodule

// File: sim/ks_select_checker.sv
`timescale 1ns / 1ps
// Checker for the k smallest selection block: predicts each run and compares results.
module ks_select_checker #(
	parameter int unsigned MAX_SELECT  = 64,
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ks_sample_if                              samples,
	ks_result_if                              results,
	input  logic                              cfg_we,
	input  logic [ks_pkg::SELECT_COUNT_W-1:0] cfg_wdata,
	output int unsigned                       mismatches,
	output int unsigned                       waiting
);
	import ks_pkg::*;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   last;
	} smallest_t;

	// Predicted chain contents, ascending, and the results still owed by the block
	logic [VALUE_WIDTH-1:0]    held [MAX_SELECT];
	int unsigned               held_count;
	logic [SELECT_COUNT_W-1:0] select_count;
	smallest_t                 due_results [$];

	// Insert after every held value not above v; drop the largest once full
	function automatic void keep_value(input logic [VALUE_WIDTH-1:0] v);
		int unsigned slot;
		int unsigned i;
		slot = held_count;
		while (slot > 0 && held[slot-1] > v)
			slot--;
		if (slot < MAX_SELECT) begin
			i = (held_count < MAX_SELECT) ? held_count : MAX_SELECT - 1;
			while (i > slot) begin
				held[i] = held[i-1];
				i--;
			end
			held[slot] = v;
			if (held_count < MAX_SELECT)
				held_count++;
		end
	endfunction

	// Queue the n = min(k, held) smallest values and start an empty set
	function automatic void close_set();
		int unsigned k;
		int unsigned n;
		smallest_t   r;
		k = (select_count > MAX_SELECT) ? MAX_SELECT : select_count;
		n = (k < held_count) ? k : held_count;
		for (int unsigned i = 0; i < n; i++) begin
			r.value = held[i];
			r.last  = (i + 1 == n);
			due_results.insert(due_results.size(), r);
		end
		held_count = 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		smallest_t want;
		if (!arst_n) begin
			select_count = SELECT_COUNT_RESET;
			held_count   = 0;
			due_results.delete();
			mismatches   = 0;
			waiting     <= 0;
		end else begin
			if (cfg_we)
				select_count = cfg_wdata;

			// Compare each result taken by the sink with the oldest expectation
			if (results.valid && results.ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$error("unexpected result: smallest_value %0d last_result %0b",
						results.smallest_value, results.last_result);
				end else begin
					want = due_results.pop_front();
					if (results.smallest_value !== want.value) begin
						mismatches++;
						$error("smallest_value: expected %0d, actual %0d",
							want.value, results.smallest_value);
					end
					if (results.last_result !== want.last) begin
						mismatches++;
						$error("last_result: expected %0b, actual %0b",
							want.last, results.last_result);
					end
				end
			end

			// Advance the prediction on each accepted sample request
			if (samples.valid && samples.ready) begin
				keep_value(samples.sample);
				if (samples.end_of_set)
					close_set();
			end

			waiting <= due_results.size();
		end
	end

endmodule

// File: sim/k_smallest_select_tb.sv
`timescale 1ns / 1ps
// Testbench top for the k smallest selection block: stimulus, flow control and verdict.
module k_smallest_select_tb;
	import ks_pkg::*;

	localparam int unsigned MAX_SELECT    = 64;
	localparam int unsigned VALUE_WIDTH   = 16;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned QUIET_LIMIT   = 3000;
	localparam int unsigned PHASE_ITEMS   = 50;

	typedef enum logic [1:0] {
		RX_STEADY,
		RX_RANDOM,
		RX_SPARSE
	} rx_mode_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [SELECT_COUNT_W-1:0] cfg_wdata;
	logic                      hold_request;
	int unsigned               burst_left;
	int unsigned               mismatches;
	int unsigned               waiting;
	int unsigned               quiet_cycles;

	ks_sample_if #(.VALUE_WIDTH(VALUE_WIDTH)) samples_ch ();
	ks_result_if #(.VALUE_WIDTH(VALUE_WIDTH)) results_ch ();

	k_smallest_select #(
		.MAX_SELECT (MAX_SELECT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_ch),
		.results  (results_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	ks_select_checker #(
		.MAX_SELECT (MAX_SELECT),
		.VALUE_WIDTH(VALUE_WIDTH)
	) run_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.mismatches(mismatches),
		.waiting   (waiting)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one sample request; open a new burst after a random gap when the last one ends
	task automatic push_sample(input logic [VALUE_WIDTH-1:0] v, input logic eos);
		if (burst_left == 0) begin
			samples_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		samples_ch.valid      <= 1'b1;
		samples_ch.sample     <= v;
		samples_ch.end_of_set <= eos;
		do
			@(posedge clk);
		while (!samples_ch.ready);
		burst_left--;
	endtask

	// Stop offering and hold until every expected result is in and the block has settled
	task automatic drain_results();
		samples_ch.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (waiting != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_select_count(input logic [SELECT_COUNT_W-1:0] k);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Receiver: stretches of steady, random and sparse acceptance, plus a long hold on request
	initial begin
		int unsigned stretch;
		int unsigned hold_left;
		rx_mode_t    mode;
		bit          hold_done;
		results_ch.ready <= 1'b0;
		stretch   = 0;
		hold_left = 0;
		hold_done = 1'b0;
		mode      = RX_STEADY;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left != 0) begin
				results_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(16, 64);
					case ($urandom_range(0, 2))
						0: mode = RX_STEADY;
						1: mode = RX_RANDOM;
						default: mode = RX_SPARSE;
					endcase
				end
				stretch--;
				case (mode)
					RX_STEADY: results_ch.ready <= 1'b1;
					RX_RANDOM: results_ch.ready <= 1'($urandom_range(0, 1));
					default:   results_ch.ready <= (stretch % 4 == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((samples_ch.valid && samples_ch.ready) || (results_ch.valid && results_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("k_smallest_select test failed");
			$finish;
		end
	end

	initial begin
		logic [SELECT_COUNT_W-1:0] k_plan [8];
		int unsigned               phase_items;
		int unsigned               set_len;
		bit                        paused;
		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		samples_ch.valid      <= 1'b0;
		samples_ch.sample     <= '0;
		samples_ch.end_of_set <= 1'b0;
		hold_request          <= 1'b0;
		burst_left = 0;
		paused     = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of one: widest value then zero
		push_sample(16'hFFFF, 1'b0);
		push_sample(16'h0000, 1'b1);
		// Count of zero: set consumed, nothing emitted
		write_select_count(7'd0);
		push_sample(16'd5, 1'b0);
		push_sample(16'd7, 1'b1);
		// Count at the limit, fewer values than asked, equal values kept apart
		write_select_count(7'd64);
		push_sample(16'd9, 1'b0);
		push_sample(16'd9, 1'b0);
		push_sample(16'd1, 1'b1);
		// Count above the limit saturates; alternating bit patterns
		write_select_count(7'd127);
		push_sample(16'hAAAA, 1'b0);
		push_sample(16'h5555, 1'b1);
		// One-value set, then a descending set cut to three
		write_select_count(7'd3);
		push_sample(16'h8000, 1'b1);
		for (int j = 6; j >= 1; j--)
			push_sample(VALUE_WIDTH'(j), j == 1);

		// Random sets over several counts, extremes among them
		k_plan = '{7'd64, 7'd0, 7'd2, 7'd127, 7'd1, 7'd0, 7'd65, 7'd5};
		k_plan[5] = SELECT_COUNT_W'($urandom_range(0, 127));
		for (int phase = 0; phase < 8; phase++) begin
			write_select_count(k_plan[phase]);
			if (phase == 3)
				hold_request <= 1'b1;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) begin
				// Pause once mid-phase until every owed result has come back
				if (phase == 5 && phase_items > 20 && !paused) begin
					drain_results();
					paused = 1'b1;
				end
				set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
					: $urandom_range(1, 12);
				for (int unsigned i = 0; i < set_len; i++)
					push_sample(VALUE_WIDTH'(($urandom_range(0, 3) == 0)
						? $urandom_range(0, 15) : $urandom_range(0, 65535)),
						i + 1 == set_len);
				phase_items += set_len;
			end
		end

		drain_results();
		if (mismatches == 0)
			$display("k_smallest_select test passed");
		else
			$display("k_smallest_select test failed");
		$finish;
	end

endmodule
